### design/ffha_pkg.sv
package ffha_pkg;

    // Defaults for the top-level parameters
    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;

    // Fixed field widths
    localparam int OFS_W  = 13;
    localparam int STAT_W = 2;

    localparam logic [OFS_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FAIL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_CLEAR    = 4'd1,
        CMD_START    = 4'd2,
        CMD_A_CHK    = 4'd3,
        CMD_A_EVAL   = 4'd4,
        CMD_A_SPLIT  = 4'd5,
        CMD_A_FIXN   = 4'd6,
        CMD_A_APPEND = 4'd7,
        CMD_F_CHK    = 4'd8,
        CMD_F_EVAL   = 4'd9,
        CMD_F_NEXT   = 4'd10,
        CMD_F_PREV   = 4'd11,
        CMD_F_PEVAL  = 4'd12,
        CMD_F_LINK   = 4'd13,
        CMD_F_FIX    = 4'd14,
        CMD_LOAD     = 4'd15
    } t_cmd;

    typedef struct packed {
        logic req_zero;
        logic walk_ok;
        logic rd_start;
        logic fits;
        logic split;
        logic off_last;
        logic nxt_in;
        logic bad_free;
        logic cur_bad;
        logic eval_next;
        logic off_zero;
        logic link_next;
        logic clr_last;
    } t_dp_status;

endpackage

### design/ffha_req_if.sv
interface ffha_req_if;
    import ffha_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [OFS_W-1:0] request_size;
    logic [OFS_W-1:0] payload_offset;

    modport source (output valid, output op, output request_size, output payload_offset,
                    input ready);
    modport sink   (input valid, input op, input request_size, input payload_offset,
                    output ready);
endinterface

### design/ffha_rsp_if.sv
interface ffha_rsp_if;
    import ffha_pkg::*;

    logic              valid;
    logic              ready;
    logic [OFS_W-1:0]  result_offset;
    logic [STAT_W-1:0] status;

    modport source (output valid, output result_offset, output status, input ready);
    modport sink   (input valid, input result_offset, input status, output ready);
endinterface

### design/ffha_ctrl.sv
module ffha_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_op,
    input  logic                 i_out_ready,
    input  ffha_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output ffha_pkg::t_cmd       o_cmd
);
    import ffha_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_A_CHK    = 15'b000000000000100,
        S_A_EVAL   = 15'b000000000001000,
        S_A_SPLIT  = 15'b000000000010000,
        S_A_FIXN   = 15'b000000000100000,
        S_A_APPEND = 15'b000000001000000,
        S_F_CHK    = 15'b000000010000000,
        S_F_EVAL   = 15'b000000100000000,
        S_F_NEXT   = 15'b000001000000000,
        S_F_PREV   = 15'b000010000000000,
        S_F_PEVAL  = 15'b000100000000000,
        S_F_LINK   = 15'b001000000000000,
        S_F_FIX    = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   load;

    assign in_acc      = (r_state == S_IDLE) && i_in_valid;
    assign load        = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd   = CMD_START;
                    n_state = (i_op == OP_FREE) ? S_F_CHK : S_A_CHK;
                end
            end
            S_A_CHK: begin
                o_cmd = CMD_A_CHK;
                if (i_status.req_zero)     n_state = S_DONE;
                else if (i_status.walk_ok) n_state = S_A_EVAL;
                else                       n_state = S_A_APPEND;
            end
            S_A_EVAL: begin
                o_cmd = CMD_A_EVAL;
                if (!i_status.rd_start)                     n_state = S_A_APPEND;
                else if (i_status.fits && i_status.split)   n_state = S_A_SPLIT;
                else if (i_status.fits)                     n_state = S_DONE;
                else if (i_status.off_last)                 n_state = S_A_APPEND;
                else                                        n_state = S_A_CHK;
            end
            S_A_SPLIT: begin
                o_cmd   = CMD_A_SPLIT;
                n_state = (!i_status.off_last && i_status.nxt_in) ? S_A_FIXN : S_DONE;
            end
            S_A_FIXN: begin
                o_cmd   = CMD_A_FIXN;
                n_state = S_DONE;
            end
            S_A_APPEND: begin
                o_cmd   = CMD_A_APPEND;
                n_state = S_DONE;
            end
            S_F_CHK: begin
                o_cmd   = CMD_F_CHK;
                n_state = i_status.bad_free ? S_DONE : S_F_EVAL;
            end
            S_F_EVAL: begin
                o_cmd = CMD_F_EVAL;
                if (i_status.cur_bad)        n_state = S_DONE;
                else if (i_status.eval_next) n_state = S_F_NEXT;
                else                         n_state = S_F_PREV;
            end
            S_F_NEXT: begin
                o_cmd   = CMD_F_NEXT;
                n_state = S_F_PREV;
            end
            S_F_PREV: begin
                o_cmd   = CMD_F_PREV;
                n_state = i_status.off_zero ? S_F_LINK : S_F_PEVAL;
            end
            S_F_PEVAL: begin
                o_cmd   = CMD_F_PEVAL;
                n_state = S_F_LINK;
            end
            S_F_LINK: begin
                o_cmd   = CMD_F_LINK;
                n_state = i_status.link_next ? S_F_FIX : S_DONE;
            end
            S_F_FIX: begin
                o_cmd   = CMD_F_FIX;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load)             n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

### design/ffha_dpath.sv
module ffha_dpath #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffha_pkg::t_cmd                 i_cmd,
    input  logic                           i_op,
    input  logic [ffha_pkg::OFS_W-1:0]     i_request_size,
    input  logic [ffha_pkg::OFS_W-1:0]     i_payload_offset,
    input  logic                           i_cfg_we,
    input  logic [ffha_pkg::OFS_W-1:0]     i_cfg_wdata,
    output ffha_pkg::t_dp_status           o_status,
    output logic [ffha_pkg::OFS_W-1:0]     o_result_offset,
    output logic [ffha_pkg::STAT_W-1:0]    o_stat
);
    import ffha_pkg::*;

    localparam int AW  = $clog2(HEAP_BYTES);
    localparam int SZW = AW + 1;
    localparam int XW  = ((SZW > OFS_W) ? SZW : OFS_W) + 2;
    localparam logic [XW-1:0] HW     = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);

    typedef struct packed {
        logic [SZW-1:0] size;
        logic [AW-1:0]  prev;
        logic           free;
        logic           start;
    } t_hdr;

    t_hdr r_mem [HEAP_BYTES];
    t_hdr r_rdata;

    logic [XW-1:0]     r_off,      n_off;
    logic [XW-1:0]     r_nxt,      n_nxt;
    logic [AW-1:0]     r_nb,       n_nb;
    logic [SZW-1:0]    r_cur_size, n_cur_size;
    logic [AW-1:0]     r_cur_prev, n_cur_prev;
    logic [OFS_W-1:0]  r_req,      n_req;
    logic              r_pay_bad,  n_pay_bad;
    logic [SZW-1:0]    r_top,      n_top;
    logic [AW-1:0]     r_last,     n_last;
    logic [OFS_W-1:0]  r_limit;
    logic [OFS_W-1:0]  r_res,      n_res;
    logic [STAT_W-1:0] r_stat,     n_stat;
    logic [OFS_W-1:0]  r_out_res;
    logic [STAT_W-1:0] r_out_stat;
    logic [AW-1:0]     r_clr;

    logic          we;
    logic [AW-1:0] wa, ra;
    t_hdr          wd;

    logic [XW-1:0] size_x, req_x, nxt_rd, nxt_cur, end_x, limit_x;

    assign size_x  = XW'(r_rdata.size);
    assign req_x   = XW'(r_req);
    assign nxt_rd  = r_off + HW + size_x;
    assign nxt_cur = r_off + HW + XW'(r_cur_size);
    assign end_x   = XW'(r_top) + HW + req_x;
    assign limit_x = (XW'(r_limit) > HEAP_X) ? HEAP_X : XW'(r_limit);

    always_comb begin
        o_status.req_zero  = (r_req == '0);
        o_status.walk_ok   = (r_top != '0) && (r_off < XW'(r_top));
        o_status.rd_start  = r_rdata.start;
        o_status.fits      = r_rdata.free && (size_x >= req_x);
        o_status.split     = size_x > (HW + req_x);
        o_status.off_last  = (r_off == XW'(r_last));
        o_status.nxt_in    = (r_nxt < HEAP_X);
        o_status.bad_free  = r_pay_bad || (r_off >= XW'(r_top));
        o_status.cur_bad   = !r_rdata.start || r_rdata.free;
        o_status.eval_next = (r_off != XW'(r_last)) && (nxt_rd < HEAP_X);
        o_status.off_zero  = (r_off == '0);
        o_status.link_next = (r_off != XW'(r_last)) && (nxt_cur < HEAP_X);
        o_status.clr_last  = (r_clr == '1);
    end

    always_comb begin
        n_off      = r_off;
        n_nxt      = r_nxt;
        n_nb       = r_nb;
        n_cur_size = r_cur_size;
        n_cur_prev = r_cur_prev;
        n_req      = r_req;
        n_pay_bad  = r_pay_bad;
        n_top      = r_top;
        n_last     = r_last;
        n_res      = r_res;
        n_stat     = r_stat;
        we         = 1'b0;
        wa         = r_off[AW-1:0];
        ra         = r_off[AW-1:0];
        wd         = '0;
        case (i_cmd)
            CMD_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
            end
            CMD_START: begin
                n_req     = i_request_size;
                n_pay_bad = (XW'(i_payload_offset) < HW);
                // an allocate starts the first-fit walk at offset zero, a free at its header
                n_off     = (i_op == OP_FREE) ? XW'(i_payload_offset) - HW : '0;
                n_res     = '0;
                n_stat    = ST_OK;
            end
            CMD_A_CHK: begin
                if (r_req == '0) n_stat = ST_FAIL;
            end
            CMD_A_EVAL: begin
                n_cur_prev = r_rdata.prev;
                n_nb       = AW'(r_off + HW + req_x);
                n_nxt      = nxt_rd;
                if (r_rdata.start && o_status.fits) begin
                    if (o_status.split) begin
                        // split off the tail as a new free block
                        we       = 1'b1;
                        wa       = AW'(r_off + HW + req_x);
                        wd.size  = SZW'(size_x - req_x - HW);
                        wd.prev  = r_off[AW-1:0];
                        wd.free  = 1'b1;
                        wd.start = 1'b1;
                    end else begin
                        we       = 1'b1;
                        wd       = r_rdata;
                        wd.free  = 1'b0;
                        n_res    = OFS_W'(r_off + HW);
                        n_stat   = ST_OK;
                    end
                end else if (r_rdata.start && !o_status.off_last) begin
                    n_off = nxt_rd;
                end
            end
            CMD_A_SPLIT: begin
                we       = 1'b1;
                wd.size  = SZW'(r_req);
                wd.prev  = r_cur_prev;
                wd.start = 1'b1;
                n_res    = OFS_W'(r_off + HW);
                n_stat   = ST_OK;
                ra       = r_nxt[AW-1:0];
                if (o_status.off_last) n_last = r_nb;
            end
            CMD_A_FIXN: begin
                wa = r_nxt[AW-1:0];
                wd = r_rdata;
                wd.prev = r_nb;
                we = r_rdata.start;
            end
            CMD_A_APPEND: begin
                if (end_x > limit_x) begin
                    n_res  = '0;
                    n_stat = ST_FAIL;
                end else begin
                    we       = 1'b1;
                    wa       = r_top[AW-1:0];
                    wd.size  = SZW'(r_req);
                    wd.prev  = (r_top == '0) ? '0 : r_last;
                    wd.start = 1'b1;
                    n_last   = r_top[AW-1:0];
                    n_res    = OFS_W'(XW'(r_top) + HW);
                    n_top    = SZW'(end_x);
                    n_stat   = ST_OK;
                end
            end
            CMD_F_CHK: begin
                if (o_status.bad_free) n_stat = ST_REJECT;
            end
            CMD_F_EVAL: begin
                n_cur_size = r_rdata.size;
                n_cur_prev = r_rdata.prev;
                n_nxt      = nxt_rd;
                ra         = nxt_rd[AW-1:0];
                if (o_status.cur_bad) n_stat = ST_REJECT;
            end
            CMD_F_NEXT: begin
                // absorb a free next block
                if (r_rdata.start && r_rdata.free) begin
                    n_cur_size = SZW'(XW'(r_cur_size) + size_x + HW);
                    we         = 1'b1;
                    wa         = r_nxt[AW-1:0];
                    if (r_nxt == XW'(r_last)) n_last = r_off[AW-1:0];
                end
            end
            CMD_F_PREV: begin
                ra = r_cur_prev;
            end
            CMD_F_PEVAL: begin
                // fold into a free previous block
                if (r_rdata.start && r_rdata.free) begin
                    we         = 1'b1;
                    if (o_status.off_last) n_last = r_cur_prev;
                    n_off      = XW'(r_cur_prev);
                    n_cur_size = SZW'(XW'(r_cur_size) + size_x + HW);
                    n_cur_prev = r_rdata.prev;
                end
            end
            CMD_F_LINK: begin
                we       = 1'b1;
                wd.size  = r_cur_size;
                wd.prev  = r_cur_prev;
                wd.free  = 1'b1;
                wd.start = 1'b1;
                n_nxt    = nxt_cur;
                ra       = nxt_cur[AW-1:0];
                n_res    = '0;
                n_stat   = ST_OK;
            end
            CMD_F_FIX: begin
                wa = r_nxt[AW-1:0];
                wd = r_rdata;
                wd.prev = r_off[AW-1:0];
                we = r_rdata.start;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rdata <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_last  <= '0;
            r_limit <= LIMIT_RESET;
            r_clr   <= '0;
        end else begin
            r_top  <= n_top;
            r_last <= n_last;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (i_cmd == CMD_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off      <= n_off;
        r_nxt      <= n_nxt;
        r_nb       <= n_nb;
        r_cur_size <= n_cur_size;
        r_cur_prev <= n_cur_prev;
        r_req      <= n_req;
        r_pay_bad  <= n_pay_bad;
        r_res      <= n_res;
        r_stat     <= n_stat;
        if (i_cmd == CMD_LOAD) begin
            r_out_res  <= r_res;
            r_out_stat <= r_stat;
        end
    end

    assign o_result_offset = r_out_res;
    assign o_stat          = r_out_stat;
endmodule

### design/first_fit_heap_allocator.sv
// First-fit heap allocator with in-heap block headers.
// Requests arrive on i_req (valid/ready): op 0 allocates request_size bytes,
// op 1 frees the block whose payload starts at payload_offset. Each request
// yields one response on o_rsp carrying result_offset and status.
// An allocate walks the block headers first-fit, reading and evaluating
// each in turn, then takes an exact fit, splits and relinks, or appends at
// the break; a size-zero allocate fails without a walk. A free is rejected
// when the offset is out of range or the header is not a live block, and
// otherwise merges with any free neighbour and relinks. The header memory
// has one read and one write port. The user must write heap_limit through
// i_cfg_we / i_cfg_wdata only while the block idles; the block itself does
// not enforce this.
// One request is worked on at a time; the next is taken once the response
// sits in the output register, so a request may be accepted while an older
// response still waits for the receiver.
// When the receiver stalls, the finished response holds in the output
// register and the following request holds in its final state.
// After reset the header memory is swept clear, one entry per cycle, and
// i_req.ready stays low meanwhile.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ffha_pkg::OFS_W-1:0] i_cfg_wdata,
    ffha_req_if.sink                   i_req,
    ffha_rsp_if.source                 o_rsp
);
    import ffha_pkg::*;

    // controller/datapath handshake
    t_cmd       cmd;
    t_dp_status status;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_op        (i_req.op),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // header memory, break, last block and limit live here
    ffha_dpath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_req.op),
        .i_request_size   (i_req.request_size),
        .i_payload_offset (i_req.payload_offset),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_status         (status),
        .o_result_offset  (o_rsp.result_offset),
        .o_stat           (o_rsp.status)
    );
endmodule
